// ===== design/rmds_pkg.sv =====
package rmds_pkg;

    // Shaping thresholds and limits.
    localparam logic [7:0]  RISE_SNAP  = 8'h29;
    localparam logic [7:0]  TOP_LEVEL  = 8'h3D;
    localparam logic [7:0]  QUAD_LOW   = 8'h33;
    localparam logic [7:0]  QUAD_PIVOT = 8'h3C;
    localparam logic [7:0]  FALL_SPAN  = 8'h1E;
    localparam logic [7:0]  FULL_DRIVE = 8'hFF;

    // The rise ramp scales by 255/40, which is 51/8 exactly.
    localparam logic [11:0] RISE_MUL   = 12'd51;
    localparam int          RISE_SHIFT = 3;
    // The fall ramp scales by 255/30, which is 17/2 exactly.
    localparam logic [8:0]  FALL_MUL   = 9'd17;

    // Energy accumulator limits.
    localparam int          ACC_W      = 11;
    localparam logic [11:0] ACC_LIMIT  = 12'h40B;
    localparam logic [10:0] ACC_CLAMP  = 11'h40A;

    // Output level is (s * 256) / ACC_LIMIT, one quotient bit per cycle.
    localparam int          DIV_STEPS  = 8;
    localparam int          STEP_W     = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHAPE,
        ST_DIV,
        ST_DONE
    } rmds_state_t;

    // Quadratic boost: floor(k * k * 255 / 100) for k = 0..8.
    function automatic logic [7:0] quad_boost(input logic [3:0] k);
        logic [7:0] v;
        begin
            case (k)
                4'd0:    v = 8'd0;
                4'd1:    v = 8'd2;
                4'd2:    v = 8'd10;
                4'd3:    v = 8'd22;
                4'd4:    v = 8'd40;
                4'd5:    v = 8'd63;
                4'd6:    v = 8'd91;
                4'd7:    v = 8'd124;
                4'd8:    v = 8'd163;
                default: v = 8'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== design/rmds_if.sv =====
interface rmds_in_if;
    logic              valid;
    logic              ready;
    logic [7:0]        level_request;
    logic [7:0]        actuator_type;
    logic signed [3:0] pad_port;
    logic [1:0]        pad_slot;

    modport source (output valid, output level_request, output actuator_type,
                    output pad_port, output pad_slot, input ready);
    modport sink   (input valid, input level_request, input actuator_type,
                    input pad_port, input pad_slot, output ready);
endinterface

interface rmds_out_if;
    logic       valid;
    logic       ready;
    logic       send_enable;
    logic [2:0] out_port;
    logic [1:0] out_slot;
    logic [7:0] out_type;
    logic [7:0] drive_value;
    logic [7:0] smoothed_level;

    modport source (output valid, output send_enable, output out_port,
                    output out_slot, output out_type, output drive_value,
                    output smoothed_level, input ready);
    modport sink   (input valid, input send_enable, input out_port,
                    input out_slot, input out_type, input drive_value,
                    input smoothed_level, output ready);
endinterface

// ===== design/rumble_motor_drive_shaper_top.sv =====
// An item passes through the input transfer, a shaping step, the bit-serial divider steps for
// the output level and a hand-over step, which waits until the output register is free; a new
// item is taken in only after that hand-over.
// A finished result waits in the output register while the next item is taken in.
// Reset (rst_n, asynchronous, active low) clears the last output level, the energy
// accumulator, the sequencer with its step counter and the output valid flag.
module rumble_motor_drive_shaper_top (
    input  logic            clk,
    input  logic            rst_n,
    rmds_in_if.sink         in_ch,
    rmds_out_if.source      out_ch
);

    // Sequencer.
    rmds_pkg::rmds_state_t state_reg, state_next;
    logic [rmds_pkg::STEP_W-1:0] step_reg;

    // Item held while it is worked on. These are payload and need no reset.
    logic [7:0]        n_reg;
    logic [7:0]        type_reg;
    logic signed [3:0] port_reg;
    logic [1:0]        slot_reg;
    logic [7:0]        drive_reg;

    // Carried state from one item to the next.
    logic [7:0]                   last_level_reg;
    logic [rmds_pkg::ACC_W-1:0]   acc_reg;

    // Divider: the partial remainder and the quotient shift register.
    logic [rmds_pkg::ACC_W-1:0]   rem_reg;
    logic [7:0]                   quot_reg;

    // Output register.
    logic       out_valid_reg;
    logic       send_reg;
    logic [2:0] oport_reg;
    logic [1:0] oslot_reg;
    logic [7:0] otype_reg;
    logic [7:0] odrive_reg;
    logic [7:0] olevel_reg;

    logic in_take;
    logic out_free;
    logic load_out;

    assign in_ch.ready = (state_reg == rmds_pkg::ST_IDLE);
    assign in_take     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;

    // ------------------------------------------------------------------
    // Shaping of the requested level against the last output level.
    // ------------------------------------------------------------------
    logic signed [8:0] diff;
    logic [7:0]        dmag;
    logic              rise;
    logic              fall;
    logic [11:0]       rise_prod;
    logic [7:0]        rise_t;
    logic [8:0]        fall_prod;
    logic [7:0]        fall_t;
    logic [7:0]        pivot_gap;
    logic [7:0]        quad_t;
    logic [7:0]        shaped;

    always_comb
    begin
        diff      = $signed({1'b0, n_reg}) - $signed({1'b0, last_level_reg});
        rise      = !diff[8] && (diff != 9'sd0);
        fall      = diff[8];
        dmag      = fall ? 8'(-diff) : diff[7:0];
        // Only used when the step is at most 40, so six bits suffice.
        rise_prod = 12'(dmag[5:0]) * rmds_pkg::RISE_MUL;
        rise_t    = rise_prod[rmds_pkg::RISE_SHIFT +: 8];
        // Only used when the fall is at most 30; the division truncates toward zero.
        fall_prod = 9'(dmag[4:0]) * rmds_pkg::FALL_MUL;
        fall_t    = rmds_pkg::FULL_DRIVE - fall_prod[8:1];
        pivot_gap = rmds_pkg::QUAD_PIVOT - n_reg;
        quad_t    = rmds_pkg::quad_boost(pivot_gap[3:0]);

        shaped = n_reg;
        if (rise)
        begin
            if (dmag >= rmds_pkg::RISE_SNAP)
            begin
                shaped = rmds_pkg::FULL_DRIVE;
            end
            else if (n_reg >= rmds_pkg::TOP_LEVEL || last_level_reg >= rmds_pkg::TOP_LEVEL)
            begin
                shaped = (last_level_reg < rise_t) ? rise_t : n_reg;
            end
            else if (last_level_reg >= rmds_pkg::QUAD_LOW)
            begin
                shaped = (last_level_reg < quad_t) ? quad_t : n_reg;
            end
            else
            begin
                shaped = rmds_pkg::FULL_DRIVE;
            end
        end
        else if (fall)
        begin
            if (dmag > rmds_pkg::FALL_SPAN)
            begin
                shaped = 8'd0;
            end
            else
            begin
                shaped = (fall_t < last_level_reg) ? fall_t : n_reg;
            end
        end
    end

    // Accumulate the drive value and clamp it below the limit.
    logic [rmds_pkg::ACC_W:0]     acc_sum;
    logic [rmds_pkg::ACC_W-1:0]   acc_clamped;
    logic [rmds_pkg::ACC_W+1:0]   acc_triple;

    always_comb
    begin
        acc_sum     = {1'b0, acc_reg} + (rmds_pkg::ACC_W+1)'(shaped);
        acc_clamped = (acc_sum >= rmds_pkg::ACC_LIMIT) ? rmds_pkg::ACC_CLAMP
                                                       : acc_sum[rmds_pkg::ACC_W-1:0];
        // Decay to three quarters: (3 * s) >> 2.
        acc_triple  = (rmds_pkg::ACC_W+2)'(acc_clamped)
                    + (rmds_pkg::ACC_W+2)'({acc_clamped, 1'b0});
    end

    // One restoring division step: the dividend is s followed by eight zero bits.
    logic [rmds_pkg::ACC_W:0] rem_shift;
    logic                     rem_ge;

    always_comb
    begin
        rem_shift = {rem_reg, 1'b0};
        rem_ge    = (rem_shift >= rmds_pkg::ACC_LIMIT);
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmds_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        case (state_reg)
            rmds_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = rmds_pkg::ST_SHAPE;
                end
            end
            rmds_pkg::ST_SHAPE:
            begin
                state_next = rmds_pkg::ST_DIV;
            end
            rmds_pkg::ST_DIV:
            begin
                if (step_reg == rmds_pkg::STEP_W'(rmds_pkg::DIV_STEPS - 1))
                begin
                    state_next = rmds_pkg::ST_DONE;
                end
            end
            rmds_pkg::ST_DONE:
            begin
                // The result moves into the output register once that is free.
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = rmds_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rmds_pkg::ST_IDLE;
            end
        endcase
    end

    // Carried state and the step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg <= '0;
            acc_reg        <= '0;
            step_reg       <= '0;
        end
        else
        begin
            if (state_reg == rmds_pkg::ST_SHAPE)
            begin
                acc_reg  <= acc_triple[rmds_pkg::ACC_W+1:2];
                step_reg <= '0;
            end
            else if (state_reg == rmds_pkg::ST_DIV)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == rmds_pkg::STEP_W'(rmds_pkg::DIV_STEPS - 1))
                begin
                    // The last quotient bit lands together with the level update.
                    last_level_reg <= {quot_reg[6:0], rem_ge};
                end
            end
        end
    end

    // Item capture, shaped drive value and the divider.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            n_reg    <= in_ch.level_request;
            type_reg <= in_ch.actuator_type;
            port_reg <= in_ch.pad_port;
            slot_reg <= in_ch.pad_slot;
        end
        if (state_reg == rmds_pkg::ST_SHAPE)
        begin
            drive_reg <= shaped;
            rem_reg   <= acc_clamped;
            quot_reg  <= '0;
        end
        else if (state_reg == rmds_pkg::ST_DIV)
        begin
            rem_reg  <= rem_ge ? rmds_pkg::ACC_W'(rem_shift - rmds_pkg::ACC_LIMIT)
                               : rem_shift[rmds_pkg::ACC_W-1:0];
            quot_reg <= {quot_reg[6:0], rem_ge};
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            // A negative port suppresses the send and reports port zero.
            send_reg   <= !port_reg[3];
            oport_reg  <= port_reg[3] ? 3'd0 : port_reg[2:0];
            oslot_reg  <= slot_reg;
            otype_reg  <= type_reg;
            odrive_reg <= drive_reg;
            olevel_reg <= quot_reg;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.send_enable    = send_reg;
    assign out_ch.out_port       = oport_reg;
    assign out_ch.out_slot       = oslot_reg;
    assign out_ch.out_type       = otype_reg;
    assign out_ch.drive_value    = odrive_reg;
    assign out_ch.smoothed_level = olevel_reg;

endmodule

// ===== design/rmds_checker.sv =====
module rmds_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       send_enable,
    input logic [2:0] out_port
);

    // Items taken in but not yet delivered; the design holds at most two.
    logic [1:0] pending_reg;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_xfer && !out_xfer)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (out_xfer && !in_xfer)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != 2'd0))
        else $error("result shown with no item outstanding");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more items outstanding than the design can hold");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("input ready stayed high after a transfer");

    a_quiet_port: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !send_enable) |-> (out_port == 3'd0))
        else $error("port reported on a result that is not sent");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result withdrawn before its transfer");

endmodule

bind rumble_motor_drive_shaper_top rmds_checker u_rmds_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .send_enable (out_ch.send_enable),
    .out_port    (out_ch.out_port)
);
